@@ rtl/core/positional_array_list_unit_assert.svh @@
// Assertion macros for the positional array list unit.
// Used by the port checker; needs nothing else.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define PALU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/palu_pkg.sv @@
// Shared types and constants for the positional array list unit.
// No dependencies.
package palu_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int POS_W      = 5;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 5;
   localparam int CAP_W      = 5;
   localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int WIDE_W     = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_UPDATE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_type;

endpackage

@@ rtl/core/palu_ctrl.sv @@
// Controller for the positional array list unit: item handshakes and sequencing.
// Depends on palu_pkg.
module palu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output palu_pkg::ctrl_type ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctrl.capture = 1'b0;
      ctrl.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               ctrl.execute = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/palu_datapath.sv @@
// Datapath for the positional array list unit: entry row, count, capacity, result register.
// Depends on palu_pkg.
module palu_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  palu_pkg::ctrl_type             ctrl,
   input  logic [palu_pkg::CMD_W-1:0]     req_cmd,
   input  logic [palu_pkg::POS_W-1:0]     req_position,
   input  logic [palu_pkg::VALUE_W-1:0]   req_value,
   input  logic                           csr_write,
   input  logic [palu_pkg::CAP_W-1:0]     csr_value,
   output logic [palu_pkg::STAT_W-1:0]    rsp_status,
   output logic [palu_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [palu_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int DW  = palu_pkg::DATA_WIDTH;
   localparam int CW  = palu_pkg::CMP_W;
   localparam logic [CW-1:0] DEPTH_X = CW'(palu_pkg::DEPTH);

   logic [palu_pkg::CMD_W-1:0]   cmd_ff;
   logic [palu_pkg::POS_W-1:0]   pos_ff;
   logic [palu_pkg::VALUE_W-1:0] val_ff;
   logic [DW-1:0]                entries_ff [palu_pkg::DEPTH];
   logic [DW-1:0]                entries_in [palu_pkg::DEPTH];
   logic [palu_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [palu_pkg::CAP_W-1:0]   cap_ff;
   logic [palu_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [palu_pkg::VALUE_W-1:0] removed_ff, removed_in;
   logic [palu_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CW-1:0]               pos_x, cnt_x, pm1_x, cap_x, eff_x, cnt_new_x;
   logic                        pos_zero, ins_ok, del_ok, upd_ok;
   logic [palu_pkg::WIDE_W-1:0] val_wide, sel_wide;
   logic [DW-1:0]               word;

   assign pos_x     = CW'(pos_ff);
   assign cnt_x     = CW'(count_ff);
   assign pm1_x     = pos_x - CW'(1);
   assign cap_x     = CW'(cap_ff);
   assign eff_x     = (cap_x < DEPTH_X) ? cap_x : DEPTH_X;
   assign pos_zero  = (pos_ff == '0);
   assign val_wide  = palu_pkg::WIDE_W'(val_ff);
   assign word      = val_wide[DW-1:0];
   assign sel_wide  = palu_pkg::WIDE_W'(entries_ff[pm1_x[palu_pkg::IDX_W-1:0]]);

   always_comb begin
      ins_ok    = 1'b0;
      del_ok    = 1'b0;
      upd_ok    = 1'b0;
      status_in = palu_pkg::STATUS_OK;
      unique case (palu_pkg::cmd_type'(cmd_ff))
         palu_pkg::CMD_INSERT: begin
            priority if (pos_zero || pos_x > cnt_x + CW'(1)) begin
               status_in = palu_pkg::STATUS_BAD_POS;
            end else if (cnt_x >= eff_x) begin
               status_in = palu_pkg::STATUS_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         palu_pkg::CMD_DELETE: begin
            if (pos_zero || pos_x > cnt_x) begin
               status_in = palu_pkg::STATUS_BAD_POS;
            end else begin
               del_ok = 1'b1;
            end
         end
         palu_pkg::CMD_UPDATE: begin
            if (pos_zero || pos_x > cnt_x) begin
               status_in = palu_pkg::STATUS_BAD_POS;
            end else begin
               upd_ok = 1'b1;
            end
         end
         default: begin
            status_in = palu_pkg::STATUS_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + palu_pkg::CNT_W'(1);
      end else if (del_ok) begin
         count_in = count_ff - palu_pkg::CNT_W'(1);
      end
   end

   assign cnt_new_x    = CW'(count_in);
   assign rsp_count_in = cnt_new_x[palu_pkg::COUNT_W-1:0];
   assign removed_in   = del_ok ? sel_wide[palu_pkg::VALUE_W-1:0] : '0;

   // one cell per entry; neighbours feed the shift
   for (genvar i = 0; i < palu_pkg::DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IX  = CW'(i);
      localparam logic [CW-1:0] IX1 = CW'(i + 1);
      logic [DW-1:0] below, above;

      if (i > 0) begin : g_below
         assign below = entries_ff[i-1];
      end else begin : g_below_edge
         assign below = entries_ff[i];
      end

      if (i < palu_pkg::DEPTH - 1) begin : g_above
         assign above = entries_ff[i+1];
      end else begin : g_above_edge
         assign above = entries_ff[i];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (ins_ok) begin
            if (IX == pm1_x) begin
               entries_in[i] = word;
            end else if (IX > pm1_x && IX <= cnt_x) begin
               entries_in[i] = below;
            end
         end else if (upd_ok) begin
            if (IX == pm1_x) begin
               entries_in[i] = word;
            end
         end else if (del_ok) begin
            if (IX >= pm1_x && IX1 < cnt_x) begin
               entries_in[i] = above;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= palu_pkg::CAP_RESET;
      end else begin
         if (ctrl.execute) begin
            count_ff <= count_in;
         end
         if (csr_write) begin
            cap_ff <= csr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (ctrl.execute) begin
         entries_ff   <= entries_in;
         status_ff    <= status_in;
         removed_ff   <= removed_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_count         = rsp_count_ff;

endmodule

@@ rtl/core/positional_array_list_unit.sv @@
// Top level of the positional array list unit: packs stream fields, joins controller and datapath.
// Depends on palu_pkg, palu_ctrl and palu_datapath.
//
//   channel | dir | fields
//   req_    | in  | tuser: cmd; tdata: position, value
//   rsp_    | out | tuser: status; tdata: removed_value, count
//   csr_    | in  | data: capacity_limit (always ready)
//
// Each item goes through capture, then execute: shift the entry row and load the result register.
// The execute step waits while an earlier result is still held on rsp_; the next item
// is taken as soon as execution is done, with the result still waiting.
// Reset empties the list and sets the capacity to 16; stored words are not cleared.
module positional_array_list_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[4:0], value[36:5], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // removed_value[31:0], count[36:32], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   palu_pkg::ctrl_type             ctrl;
   logic [palu_pkg::STAT_W-1:0]    status;
   logic [palu_pkg::VALUE_W-1:0]   removed_value;
   logic [palu_pkg::COUNT_W-1:0]   count;

   assign csr_ready = 1'b1;

   palu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   palu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_cmd           (req_tuser),
      .req_position      (req_tdata[4:0]),
      .req_value         (req_tdata[36:5]),
      .csr_write         (csr_valid && csr_ready),
      .csr_value         (csr_data),
      .rsp_status        (status),
      .rsp_removed_value (removed_value),
      .rsp_count         (count)
   );

   assign rsp_tdata = {3'b000, count, removed_value};
   assign rsp_tuser = status;

endmodule

@@ rtl/core/palu_checker.sv @@
// Port-level checker for the positional array list unit, bound to the top level.
// Depends on palu_pkg and positional_array_list_unit_assert.svh.
`include "positional_array_list_unit_assert.svh"

module palu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `PALU_ASSERT_NEXT(a_one_item_at_a_time, clock, reset,
      req_tvalid && req_tready, !req_tready,
      "item taken while another is in flight")
   `PALU_ASSERT_NOW(a_count_bound, clock, reset,
      rsp_tvalid, rsp_tdata[36:32] <= 5'(palu_pkg::DEPTH),
      "count beyond depth")
   `PALU_ASSERT_NOW(a_removed_only_ok, clock, reset,
      rsp_tvalid && rsp_tuser != palu_pkg::STATUS_OK, rsp_tdata[31:0] == 32'd0,
      "removed word on a rejected item")
   `PALU_ASSERT_NOW(a_status_code, clock, reset,
      rsp_tvalid, rsp_tuser <= 2'(palu_pkg::STATUS_FULL),
      "unknown status code")
   `PALU_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result changed")

endmodule

bind positional_array_list_unit palu_checker u_palu_checker (.*);

@@ sim/positional_array_list_unit_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the positional array list unit: watches the request, response and CSR streams.
// Keeps a shadow copy of the list and capacity to predict each response. Needs palu_pkg.
module positional_array_list_unit_checker
   import palu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [39:0]        req_tdata,   // position[4:0], value[36:5], zero pad
   input  logic [1:0]         req_tuser,   // cmd[1:0]
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [39:0]        rsp_tdata,   // removed_value[31:0], count[36:32], zero pad
   input  logic [1:0]         rsp_tuser,   // status[1:0]
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CAP_W-1:0]   csr_data,
   output int                 failures,
   output int                 outstanding,
   output logic [COUNT_W-1:0] list_length
);

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] removed;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   logic [VALUE_W-1:0] shadow_words [DEPTH];
   logic [CAP_W-1:0]   shadow_capacity;
   outcome_type        awaited_outcomes [$];

   function automatic outcome_type apply_command(input logic [CMD_W-1:0] code,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VALUE_W-1:0] word);
      outcome_type res;
      int n;
      int p;
      int room;
      n = list_length;
      p = pos;
      room = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
      res.status = STATUS_OK;
      res.removed = '0;
      case (code)
         CMD_INSERT: begin
            if (p < 1 || p > n + 1) begin
               res.status = STATUS_BAD_POS;
            end else if (n >= room) begin
               res.status = STATUS_FULL;
            end else begin
               for (int j = n; j >= p; j--) shadow_words[j] = shadow_words[j-1];
               shadow_words[p-1] = word;
               n++;
            end
         end
         CMD_DELETE: begin
            if (p < 1 || p > n) begin
               res.status = STATUS_BAD_POS;
            end else begin
               res.removed = shadow_words[p-1];
               for (int j = p; j < n; j++) shadow_words[j-1] = shadow_words[j];
               n--;
            end
         end
         CMD_UPDATE: begin
            if (p < 1 || p > n) res.status = STATUS_BAD_POS;
            else shadow_words[p-1] = word;
         end
         default: ;  // spare code: no-op
      endcase
      list_length = COUNT_W'(n);
      res.count = COUNT_W'(n);
      return res;
   endfunction

   initial begin
      failures = 0;
      outstanding = 0;
      list_length = '0;
      shadow_capacity = CAP_RESET;
   end

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         list_length = '0;
         shadow_capacity = CAP_RESET;
         awaited_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_outcomes.size() == 0) begin
               failures++;
               $display("%0t: unexpected response item, status %0d removed %h count %0d",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[36:32]);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_tuser !== want.status) begin
                  failures++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
               end
               if (rsp_tdata[31:0] !== want.removed) begin
                  failures++;
                  $display("%0t: removed_value expected %h actual %h",
                           $time, want.removed, rsp_tdata[31:0]);
               end
               if (rsp_tdata[36:32] !== want.count) begin
                  failures++;
                  $display("%0t: count expected %0d actual %0d",
                           $time, want.count, rsp_tdata[36:32]);
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_outcomes.push_back(apply_command(req_tuser, req_tdata[4:0],
                                                     req_tdata[36:5]));
         if (csr_valid && csr_ready) shadow_capacity = csr_data;
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

@@ sim/positional_array_list_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the positional array list unit: clock, reset, stimulus and verdict.
// Depends on palu_pkg, the unit itself and positional_array_list_unit_checker.
module positional_array_list_unit_test;
   import palu_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata = '0;   // position[4:0], value[36:5], zero pad
   logic [1:0]         req_tuser = '0;   // cmd[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [39:0]        rsp_tdata;        // removed_value[31:0], count[36:32], zero pad
   logic [1:0]         rsp_tuser;        // status[1:0]
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_data = '0;

   int                 failures;
   int                 outstanding;
   logic [COUNT_W-1:0] list_length;
   bit                 calm = 1'b0;
   bit                 hold_request = 1'b0;

   always #5 clock = ~clock;

   positional_array_list_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   positional_array_list_unit_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding),
      .list_length (list_length)
   );

   task automatic send_item(input logic [CMD_W-1:0] code, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] word);
      if (!calm && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 36);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {3'b000, word, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_list_ops();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      drain_list_ops();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed positions against the current length, some anywhere in range
   task automatic random_list_op();
      int               roll;
      int               top_pos;
      logic [CMD_W-1:0] code;
      logic [POS_W-1:0] pos;
      logic [VALUE_W-1:0] word;
      roll = $urandom_range(99);
      if (roll < 40) code = CMD_INSERT;
      else if (roll < 70) code = CMD_DELETE;
      else if (roll < 93) code = CMD_UPDATE;
      else code = CMD_SPARE;
      top_pos = list_length + ((code == CMD_INSERT) ? 1 : 0);
      if (top_pos > 0 && $urandom_range(99) < 80) pos = POS_W'($urandom_range(top_pos, 1));
      else pos = POS_W'($urandom_range(31, 0));
      case ($urandom_range(9))
         0: word = '0;
         1: word = '1;
         default: word = $urandom();
      endcase
      send_item(code, pos, word);
   endtask

   task automatic random_run(input int n);
      repeat (n) random_list_op();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 36);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_capacity(5'd16);

      // empty list, bad positions
      send_item(CMD_UPDATE, 5'd1, 32'h1234_5678);
      send_item(CMD_DELETE, 5'd1, '0);
      send_item(CMD_INSERT, 5'd0, 32'hDEAD_BEEF);
      send_item(CMD_INSERT, 5'd2, 32'hDEAD_BEEF);
      // head, middle and tail inserts
      send_item(CMD_INSERT, 5'd1, 32'h0000_0000);
      send_item(CMD_INSERT, 5'd1, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 5'd3, 32'hA5A5_A5A5);
      send_item(CMD_INSERT, 5'd2, 32'h5A5A_5A5A);
      send_item(CMD_UPDATE, 5'd2, 32'h8000_0001);
      send_item(CMD_UPDATE, 5'd31, 32'h0F0F_0F0F);
      send_item(CMD_SPARE, 5'd31, 32'hFFFF_FFFF);
      send_item(CMD_DELETE, 5'd4, '0);
      send_item(CMD_DELETE, 5'd0, '0);
      send_item(CMD_INSERT, 5'd5, 32'h1111_1111);
      // full list; position check wins over full check
      set_capacity(5'd3);
      send_item(CMD_INSERT, 5'd4, 32'h2222_2222);
      send_item(CMD_INSERT, 5'd31, 32'h3333_3333);
      // zero capacity: inserts refused, deletes and updates still work
      set_capacity(5'd0);
      send_item(CMD_INSERT, 5'd1, 32'h4444_4444);
      send_item(CMD_UPDATE, 5'd3, 32'hC3C3_C3C3);
      send_item(CMD_DELETE, 5'd1, '0);
      set_capacity(5'd2);
      send_item(CMD_INSERT, 5'd1, 32'h5555_5555);
      send_item(CMD_DELETE, 5'd2, '0);
      send_item(CMD_DELETE, 5'd1, '0);

      set_capacity(5'd16);
      random_run(300);
      set_capacity(5'd1);
      random_run(100);

      set_capacity(5'd16);
      calm = 1'b1;
      random_run(200);
      calm = 1'b0;

      set_capacity(CAP_W'($urandom_range(15, 2)));
      random_run(100);
      hold_request = 1'b1;
      random_run(150);

      set_capacity(CAP_W'($urandom_range(16, 1)));
      random_run(200);
      set_capacity(5'd16);
      random_run(200);

      req_tvalid <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
